// ===== rtl/core/sws_pkg.sv =====
// Package for the stop-and-wait packet sender: codes, sizes, the command
// record passed from the front end to the back end, and the back end states.
// No dependencies.
`default_nettype none
package sws_pkg;
	localparam int MAX_FRAME_BYTES_DEF = 64;
	localparam int HEADER_BYTES = 6;
	localparam int IDX_W = 7;
	localparam int ACC_W = 22;
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = 2;

	localparam logic [IDX_W-1:0] MIN_FRAME_LEN = 7'd8;

	localparam logic [1:0] OP_PAYLOAD = 2'd0;
	localparam logic [1:0] OP_RX      = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;

	localparam logic [1:0] RK_TX      = 2'd0;
	localparam logic [1:0] RK_ACK     = 2'd1;
	localparam logic [1:0] RK_GAVE_UP = 2'd2;

	localparam logic [2:0] CFG_NODE    = 3'd0;
	localparam logic [2:0] CFG_DEST    = 3'd1;
	localparam logic [2:0] CFG_RELAY   = 3'd2;
	localparam logic [2:0] CFG_SIZE    = 3'd3;
	localparam logic [2:0] CFG_LIMIT   = 3'd4;
	localparam logic [2:0] CFG_TIMEOUT = 3'd5;

	localparam logic [7:0] TYPE_DATA = 8'h01;
	localparam logic [7:0] TYPE_ACK  = 8'h02;
	localparam logic [7:0] SEQ_LAST  = 8'd254;

	typedef struct packed {
		logic             wr;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
		logic             build;
		logic             emit;
		logic             rep;
		logic [1:0]       rep_kind;
		logic [IDX_W-1:0] len;
		logic [IDX_W-1:0] cnt;
		logic [7:0]       node;
		logic [7:0]       dest;
		logic [7:0]       seq;
		logic [7:0]       relay;
	} cmd_t;

	typedef enum logic [3:0] {
		B_IDLE, B_BLD, B_TAIL, B_FOLD1, B_FOLD2, B_CK_HI, B_CK_LO, B_EM_RD, B_EM_WT, B_REP
	} back_state_t;
endpackage
`default_nettype wire

// ===== rtl/core/stop_and_wait_packet_sender.sv =====
// Stop-and-wait packet sender. Any item is taken while the four-entry
// command queue has room. A frame is built one byte a cycle from header,
// payload and padding, then given its checksum, and then emitted byte by
// byte as the output register frees; an ACK or give-up report follows it.
// Asynchronous reset clears control state and restores register defaults;
// the frame memory is not cleared.
`default_nettype none
module stop_and_wait_packet_sender #(
	parameter int MAX_FRAME_BYTES = sws_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       result_kind,
	output logic [7:0]       tx_byte,
	output logic             end_of_frame,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import sws_pkg::*;

	cmd_t front_cmd, head_cmd;
	logic front_push, q_empty, q_pop;

	sws_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .operation(operation),
		.data_byte(data_byte), .last_byte(last_byte), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .fifo_full(full),
		.cmd_push(front_push), .cmd(front_cmd)
	);

	sws_cmd_fifo u_queue (
		.clk(clk), .arst_n(arst_n), .push(front_push), .din(front_cmd), .full(full),
		.pop(q_pop), .dout(head_cmd), .empty(q_empty)
	);

	sws_back #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(!q_empty), .cmd(head_cmd),
		.cmd_pop(q_pop), .empty(empty), .pop(pop), .result_kind(result_kind),
		.tx_byte(tx_byte), .end_of_frame(end_of_frame)
	);
endmodule
`default_nettype wire

// ===== rtl/core/sws_front.sv =====
// Front end: configuration registers, exchange state and command issue.
// Depends on sws_pkg.
`default_nettype none
module sws_front #(
	parameter int MAX_FRAME_BYTES = sws_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire logic [1:0]          operation,
	input  wire logic [7:0]          data_byte,
	input  wire logic                last_byte,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [15:0]         cfg_data,
	input  wire logic                fifo_full,
	output logic                     cmd_push,
	output sws_pkg::cmd_t            cmd
);
	import sws_pkg::*;

	localparam logic [IDX_W-1:0] MAX_LEN = IDX_W'(MAX_FRAME_BYTES);

	logic [7:0]       node_q, dest_q, relay_q, limit_q, seq_q, retry_q;
	logic [IDX_W-1:0] psize_q, pc_q, rxpos_q;
	logic [15:0]      timeout_q, elapsed_q;
	logic [7:0]       rx1_q, rx3_q, rx4_q;
	logic             await_q;

	logic [7:0]       seq_d, retry_d, rx1_d, rx3_d, rx4_d;
	logic [IDX_W-1:0] pc_d, rxpos_d, len, room, pc_inc;
	logic [15:0]      elapsed_d, el_inc;
	logic             await_d, accept;

	assign accept = push && !fifo_full;

	always_comb begin
		if (psize_q < MIN_FRAME_LEN) len = MIN_FRAME_LEN;
		else if (psize_q > MAX_LEN) len = MAX_LEN;
		else len = psize_q;
		room = len - MIN_FRAME_LEN;
	end

	always_comb begin
		seq_d = seq_q;
		retry_d = retry_q;
		elapsed_d = elapsed_q;
		await_d = await_q;
		pc_d = pc_q;
		rxpos_d = rxpos_q;
		rx1_d = rx1_q;
		rx3_d = rx3_q;
		rx4_d = rx4_q;
		pc_inc = pc_q + 7'd1;
		el_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
		cmd_push = 1'b0;
		cmd = '0;
		cmd.len = len;
		cmd.node = node_q;
		cmd.dest = dest_q;
		cmd.seq = seq_q;
		cmd.relay = relay_q;
		cmd.addr = 7'(HEADER_BYTES) + pc_q;
		cmd.data = data_byte;
		if (accept) begin
			unique case (operation)
				OP_PAYLOAD: begin
					if (!await_q) begin
						if (pc_q < room) begin
							cmd.wr = 1'b1;
							pc_d = pc_inc;
						end
						if (last_byte) begin
							cmd.build = 1'b1;
							cmd.emit = 1'b1;
							cmd.cnt = (pc_d > room) ? room : pc_d;
							pc_d = '0;
							await_d = 1'b1;
							retry_d = '0;
							elapsed_d = '0;
						end
						cmd_push = cmd.wr || last_byte;
					end
				end
				OP_RX: begin
					if (rxpos_q == 7'd1) rx1_d = data_byte;
					if (rxpos_q == 7'd3) rx3_d = data_byte;
					if (rxpos_q == 7'd4) rx4_d = data_byte;
					if (rxpos_q != 7'd127) rxpos_d = rxpos_q + 7'd1;
					if (last_byte) begin
						rxpos_d = '0;
						rx1_d = '0;
						rx3_d = '0;
						rx4_d = '0;
						if (await_q) begin
							if (retry_q > limit_q) begin
								cmd.rep = 1'b1;
								cmd.rep_kind = RK_GAVE_UP;
							end else if ((rxpos_q == 7'd1 ? data_byte : rx1_q) == node_q
									&& (rxpos_q == 7'd4 ? data_byte : rx4_q) == seq_q
									&& (rxpos_q == 7'd3 ? data_byte : rx3_q) == TYPE_ACK) begin
								cmd.rep = 1'b1;
								cmd.rep_kind = RK_ACK;
							end
						end
					end
				end
				OP_TICK: begin
					if (await_q) begin
						if (retry_q > limit_q) begin
							cmd.rep = 1'b1;
							cmd.rep_kind = RK_GAVE_UP;
						end else if (el_inc > timeout_q) begin
							retry_d = (retry_q == 8'hFF) ? retry_q : retry_q + 8'd1;
							elapsed_d = '0;
							cmd.emit = 1'b1;
							cmd_push = 1'b1;
						end else begin
							elapsed_d = el_inc;
						end
					end
				end
				default: ;
			endcase
			// A finished exchange, acknowledged or abandoned.
			if (cmd.rep) begin
				cmd_push = 1'b1;
				await_d = 1'b0;
				retry_d = '0;
				elapsed_d = '0;
				seq_d = (seq_q == SEQ_LAST) ? 8'd0 : seq_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= '0;
			dest_q <= '0;
			relay_q <= '0;
			psize_q <= 7'd14;
			limit_q <= 8'd3;
			timeout_q <= 16'd5000;
			seq_q <= '0;
			retry_q <= '0;
			elapsed_q <= '0;
			await_q <= 1'b0;
			pc_q <= '0;
			rxpos_q <= '0;
			rx1_q <= '0;
			rx3_q <= '0;
			rx4_q <= '0;
		end else begin
			seq_q <= seq_d;
			retry_q <= retry_d;
			elapsed_q <= elapsed_d;
			await_q <= await_d;
			pc_q <= pc_d;
			rxpos_q <= rxpos_d;
			rx1_q <= rx1_d;
			rx3_q <= rx3_d;
			rx4_q <= rx4_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_NODE:    node_q <= cfg_data[7:0];
					CFG_DEST:    dest_q <= cfg_data[7:0];
					CFG_RELAY:   relay_q <= cfg_data[7:0];
					CFG_SIZE:    psize_q <= cfg_data[6:0];
					CFG_LIMIT:   limit_q <= cfg_data[7:0];
					CFG_TIMEOUT: timeout_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!await_q |-> (elapsed_q == 16'd0 && retry_q == 8'd0))
		else $error("timer or retry count not clear while idle");
	a_seq_range: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q != 8'hFF)
		else $error("sequence number out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !fifo_full)
		else $error("command issued into a full queue");
endmodule
`default_nettype wire

// ===== rtl/core/sws_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on sws_pkg.
`default_nettype none
module sws_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  sws_pkg::cmd_t      din,
	output logic               full,
	input  wire logic          pop,
	output sws_pkg::cmd_t      dout,
	output logic               empty
);
	import sws_pkg::*;

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_q, rd_q;
	logic [CMDQ_PTR_W:0]   count_q;
	logic                  do_push, do_pop;

	assign full = (count_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
	assign empty = (count_q == '0);
	assign dout = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/sws_back.sv =====
// Back end: frame memory, header and checksum build, frame emission and
// the result register. Depends on sws_pkg.
`default_nettype none
module sws_back #(
	parameter int MAX_FRAME_BYTES = sws_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  sws_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output logic               empty,
	input  wire logic          pop,
	output logic [1:0]         result_kind,
	output logic [7:0]         tx_byte,
	output logic               end_of_frame
);
	import sws_pkg::*;

	localparam int AW = $clog2(MAX_FRAME_BYTES);

	logic [7:0]       frame_mem [MAX_FRAME_BYTES];
	logic [7:0]       rdata_q;
	back_state_t      st_q, st_d;
	cmd_t             cur_q, cur_d;
	logic [IDX_W-1:0] i_q, i_d, body;
	logic [ACC_W-1:0] acc_q, acc_d, addend;
	logic             pend_v_q, pend_v_d, pend_mem_q, pend_mem_d, pend_odd_q, pend_odd_d;
	logic [7:0]       pend_val_q, pend_val_d, byte_in, hdr;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [7:0]       wdata;
	logic             out_v_q, out_free, load;
	logic [1:0]       load_kind, kind_q;
	logic [7:0]       load_byte, byte_q;
	logic             load_eof, eof_q;

	assign body = cur_q.len - 7'd2;
	assign byte_in = pend_mem_q ? rdata_q : pend_val_q;
	assign addend = pend_odd_q ? ACC_W'({8'd0, byte_in}) : ACC_W'({byte_in, 8'd0});
	assign out_free = !out_v_q || pop;

	always_comb begin
		case (i_q)
			7'd0: hdr = cur_q.node;
			7'd1: hdr = cur_q.dest;
			7'd3: hdr = TYPE_DATA;
			7'd4: hdr = cur_q.seq;
			7'd5: hdr = cur_q.relay;
			default: hdr = 8'd0;
		endcase
	end

	always_comb begin
		st_d = st_q;
		cur_d = cur_q;
		i_d = i_q;
		acc_d = acc_q;
		pend_v_d = 1'b0;
		pend_mem_d = pend_mem_q;
		pend_val_d = pend_val_q;
		pend_odd_d = pend_odd_q;
		cmd_pop = 1'b0;
		we = 1'b0;
		waddr = i_q;
		wdata = 8'd0;
		load = 1'b0;
		load_kind = RK_TX;
		load_byte = rdata_q;
		load_eof = 1'b0;
		unique case (st_q)
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					cur_d = cmd;
					i_d = '0;
					acc_d = '0;
					we = cmd.wr;
					waddr = cmd.addr;
					wdata = cmd.data;
					if (cmd.build) st_d = B_BLD;
					else if (cmd.emit) st_d = B_EM_RD;
					else if (cmd.rep) st_d = B_REP;
				end
			end
			B_BLD: begin
				// Header and padding are written here; payload comes from memory.
				if (pend_v_q) acc_d = acc_q + addend;
				pend_v_d = 1'b1;
				pend_odd_d = i_q[0];
				if (i_q < 7'(HEADER_BYTES)) begin
					we = 1'b1;
					wdata = hdr;
					pend_mem_d = 1'b0;
					pend_val_d = hdr;
				end else if (i_q < 7'(HEADER_BYTES) + cur_q.cnt) begin
					pend_mem_d = 1'b1;
				end else begin
					we = 1'b1;
					pend_mem_d = 1'b0;
					pend_val_d = 8'd0;
				end
				if (i_q == body - 7'd1) st_d = B_TAIL;
				else i_d = i_q + 7'd1;
			end
			B_TAIL: begin
				if (pend_v_q) acc_d = acc_q + addend;
				st_d = B_FOLD1;
			end
			B_FOLD1: begin
				acc_d = ACC_W'(acc_q[ACC_W-1:16]) + ACC_W'(acc_q[15:0]);
				st_d = B_FOLD2;
			end
			B_FOLD2: begin
				acc_d = ACC_W'(acc_q[ACC_W-1:16]) + ACC_W'(acc_q[15:0]);
				st_d = B_CK_HI;
			end
			B_CK_HI: begin
				we = 1'b1;
				waddr = cur_q.len - 7'd2;
				wdata = ~acc_q[15:8];
				st_d = B_CK_LO;
			end
			B_CK_LO: begin
				we = 1'b1;
				waddr = cur_q.len - 7'd1;
				wdata = ~acc_q[7:0];
				i_d = '0;
				st_d = B_EM_RD;
			end
			B_EM_RD: st_d = B_EM_WT;
			B_EM_WT: begin
				if (out_free) begin
					load = 1'b1;
					load_eof = (i_q == cur_q.len - 7'd1);
					if (load_eof) st_d = cur_q.rep ? B_REP : B_IDLE;
					else begin
						i_d = i_q + 7'd1;
						st_d = B_EM_RD;
					end
				end
			end
			B_REP: begin
				if (out_free) begin
					load = 1'b1;
					load_kind = cur_q.rep_kind;
					load_byte = 8'd0;
					st_d = B_IDLE;
				end
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) frame_mem[waddr[AW-1:0]] <= wdata;
		rdata_q <= frame_mem[i_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		acc_q <= acc_d;
		pend_mem_q <= pend_mem_d;
		pend_val_q <= pend_val_d;
		pend_odd_q <= pend_odd_d;
		if (load) begin
			kind_q <= load_kind;
			byte_q <= load_byte;
			eof_q <= load_eof;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			i_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			i_q <= i_d;
			pend_v_q <= pend_v_d;
			if (load) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
		end
	end

	assign empty = !out_v_q;
	assign result_kind = kind_q;
	assign tx_byte = byte_q;
	assign end_of_frame = eof_q;
endmodule
`default_nettype wire
